>>> rtl/generational_handle_table_macros.svh
// Assertion helpers shared by the handle table RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHT_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GHT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ghtbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ghtbl_pkg;

    localparam int CLASS_W  = 8;
    localparam int GEN_W    = 8;
    localparam int IDX_W    = 16;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 38;
    localparam int COUNT_W  = 7;

    localparam logic [WORD_W-1:0] SAT32 = 32'hFFFF_FFFF;

    // Transaction kinds as they arrive on the kind port.
    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_RELEASE  = 2'd1;
    localparam logic [1:0] KIND_EVICT    = 2'd2;

    // Operation that the cell chain carries out for one transaction.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_CLAIM = 2'd1,
        OP_FREE  = 2'd2,
        OP_EVICT = 2'd3
    } op_t;

    // Command broadcast to every cell while a scan is running.
    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] owner;
        logic [IDX_W-1:0]  hidx;
        logic [GEN_W-1:0]  hgen;
    } cmd_t;

    // Scan token handed from one cell to the next.
    typedef struct packed {
        logic valid;
        logic found;
    } tok_t;

    // Event reported by the cell that the token is visiting; zero otherwise.
    typedef struct packed {
        logic              claim;
        logic              freed;
        logic              stale;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
        logic [WORD_W-1:0] bytes;
    } cell_evt_t;

endpackage

`default_nettype wire

>>> rtl/ghtbl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ghtbl_cell #(
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ghtbl_pkg::cmd_t      cmd,
    input  logic [31:0]          cost,
    input  ghtbl_pkg::tok_t      tok_in,
    output ghtbl_pkg::tok_t      tok_out,
    output ghtbl_pkg::cell_evt_t evt
);

    logic                            used_reg;
    logic                            used_next;
    logic [ghtbl_pkg::GEN_W-1:0]     gen_reg;
    logic [ghtbl_pkg::GEN_W-1:0]     gen_next;
    logic [ghtbl_pkg::WORD_W-1:0]    owner_reg;
    logic [ghtbl_pkg::WORD_W-1:0]    bytes_reg;
    ghtbl_pkg::tok_t                 tok_reg;
    ghtbl_pkg::tok_t                 tok_next;

    logic act;
    logic do_claim;
    logic hit_free;
    logic good_free;
    logic do_evict;
    logic freeing;

    assign act       = tok_in.valid;
    assign do_claim  = act && (cmd.op == ghtbl_pkg::OP_CLAIM) && !tok_in.found && !used_reg;
    assign hit_free  = act && (cmd.op == ghtbl_pkg::OP_FREE)
                       && (cmd.hidx == ghtbl_pkg::IDX_W'(INDEX));
    assign good_free = hit_free && used_reg && (gen_reg == cmd.hgen);
    assign do_evict  = act && (cmd.op == ghtbl_pkg::OP_EVICT) && used_reg
                       && (owner_reg == cmd.owner);
    assign freeing   = good_free || do_evict;

    always_comb
    begin
        used_next = used_reg;
        gen_next  = gen_reg;
        if (do_claim)
        begin
            used_next = 1'b1;
        end
        if (freeing)
        begin
            used_next = 1'b0;
            gen_next  = gen_reg + ghtbl_pkg::GEN_W'(1);
        end
        tok_next.valid = act;
        tok_next.found = tok_in.found | do_claim;
    end

    always_comb
    begin
        evt.claim = do_claim;
        evt.freed = freeing;
        evt.stale = hit_free && !good_free;
        evt.idx   = do_claim ? ghtbl_pkg::IDX_W'(INDEX) : '0;
        evt.gen   = do_claim ? gen_reg : '0;
        evt.bytes = freeing ? bytes_reg : '0;
    end

    assign tok_out = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            gen_reg  <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            gen_reg  <= gen_next;
            tok_reg  <= tok_next;
        end
    end

    // Owner and cost are only read while the slot is in use.
    always_ff @(posedge clk)
    begin
        if (do_claim)
        begin
            owner_reg <= cmd.owner;
            bytes_reg <= cost;
        end
    end

endmodule

`default_nettype wire

>>> rtl/generational_handle_table.sv
// Generational handle table for one resource class.
// A transaction is accepted on a rising edge with start high and busy low; kind,
// owner_id, byte_count and handle are sampled at that edge. Kind 0 claims the
// lowest free slot, kind 1 releases the slot named by a handle, kind 2 releases
// every slot of owner_id (if nonzero), and kind 3 only reports the totals.
// Each transaction produces exactly one result, shown for one cycle with done
// high. The receiver cannot stall, so the result is taken in that cycle.
// The scan token walks the chain of slot cells one cell per cycle for every kind
// of transaction; done rises once the token has left the last cell, and busy
// drops in the cycle after done, so a new transaction can only be accepted once
// the previous one has produced its result.
// The user writes the class code via cfg_write_en / cfg_write_data while busy is
// low, unchecked by the block; used for new handles and checking released handles.
// Reset frees every slot, clears all generations, totals, peaks and audit
// counters, and sets the class code to 1. No clearing pass is needed: the
// slot state lives in flip-flops inside the cells.
`timescale 1ns / 1ps
`default_nettype none

`include "generational_handle_table_macros.svh"

module generational_handle_table #(
    parameter int SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] owner_id,
    input  logic [31:0] byte_count,
    input  logic [31:0] handle,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    output logic        done,
    output logic [31:0] handle_out,
    output logic        ok,
    output logic [6:0]  released_count,
    output logic [6:0]  live_count,
    output logic [6:0]  live_peak,
    output logic [37:0] byte_total,
    output logic [37:0] byte_high_water,
    output logic [31:0] full_failures,
    output logic [31:0] stale_releases
);

    // Live counts must be able to hold SLOTS itself.
    localparam int LW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_REPORT = 3'b100
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic                         launch_reg;
    logic                         launch_next;
    ghtbl_pkg::cmd_t              cmd_reg;
    ghtbl_pkg::cmd_t              cmd_next;
    logic [31:0]                  cost_reg;
    logic [31:0]                  cost_next;
    logic [7:0]                   class_reg;
    logic [7:0]                   class_next;
    logic [31:0]                  hout_reg;
    logic [31:0]                  hout_next;
    logic                         ok_reg;
    logic                         ok_next;
    logic [6:0]                   rel_reg;
    logic [6:0]                   rel_next;
    logic [LW-1:0]                live_reg;
    logic [LW-1:0]                live_next;
    logic [LW-1:0]                live_peak_reg;
    logic [LW-1:0]                live_peak_next;
    logic [37:0]                  bytes_reg;
    logic [37:0]                  bytes_next;
    logic [37:0]                  bytes_peak_reg;
    logic [37:0]                  bytes_peak_next;
    logic [31:0]                  full_reg;
    logic [31:0]                  full_next;
    logic [31:0]                  stale_reg;
    logic [31:0]                  stale_next;

    ghtbl_pkg::tok_t              tok_chain [0:SLOTS];
    ghtbl_pkg::cell_evt_t         evt_cell  [0:SLOTS-1];
    ghtbl_pkg::cell_evt_t         evt_all;
    logic [SLOTS-1:0]             evt_hits;
    logic                         chain_done;
    logic                         accept;
    logic                         handle_valid;

    // The token enters the first cell in the cycle after a transaction is taken.
    assign tok_chain[0] = '{valid: launch_reg, found: 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            ghtbl_cell #(
                .INDEX(gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd_reg),
                .cost    (cost_reg),
                .tok_in  (tok_chain[gi]),
                .tok_out (tok_chain[gi+1]),
                .evt     (evt_cell[gi])
            );
        end
    endgenerate

    // Only the visited cell reports a nonzero event, so an OR collects it.
    always_comb
    begin
        evt_all = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            evt_all  = ghtbl_pkg::cell_evt_t'(evt_all | evt_cell[i]);
            evt_hits[i] = evt_cell[i].claim | evt_cell[i].freed | evt_cell[i].stale;
        end
    end

    assign chain_done = tok_chain[SLOTS].valid;
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign done       = (state_reg == ST_REPORT);

    // A release handle must carry this class, be nonzero and index a real slot.
    assign handle_valid = (handle[31:24] == class_reg) && (handle != '0)
                          && ({1'b0, handle[15:0]} < 17'(SLOTS));

    always_comb
    begin
        state_next      = state_reg;
        launch_next     = 1'b0;
        cmd_next        = cmd_reg;
        cost_next       = cost_reg;
        class_next      = class_reg;
        hout_next       = hout_reg;
        ok_next         = ok_reg;
        rel_next        = rel_reg;
        live_next       = live_reg;
        live_peak_next  = live_peak_reg;
        bytes_next      = bytes_reg;
        bytes_peak_next = bytes_peak_reg;
        full_next       = full_reg;
        stale_next      = stale_reg;

        if (cfg_write_en)
        begin
            class_next = cfg_write_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next.owner = owner_id;
                    cmd_next.hidx  = handle[15:0];
                    cmd_next.hgen  = handle[23:16];
                    case (kind)
                        ghtbl_pkg::KIND_REGISTER:
                            cmd_next.op = ghtbl_pkg::OP_CLAIM;
                        ghtbl_pkg::KIND_RELEASE:
                            cmd_next.op = handle_valid ? ghtbl_pkg::OP_FREE
                                                       : ghtbl_pkg::OP_NONE;
                        ghtbl_pkg::KIND_EVICT:
                            cmd_next.op = (owner_id != '0) ? ghtbl_pkg::OP_EVICT
                                                           : ghtbl_pkg::OP_NONE;
                        default:
                            cmd_next.op = ghtbl_pkg::OP_NONE;
                    endcase
                    cost_next   = byte_count;
                    hout_next   = '0;
                    ok_next     = 1'b0;
                    rel_next    = '0;
                    launch_next = 1'b1;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (evt_all.claim)
                begin
                    hout_next = {class_reg, evt_all.gen, evt_all.idx};
                    ok_next   = 1'b1;
                    live_next = live_reg + LW'(1);
                    if (live_next > live_peak_reg)
                    begin
                        live_peak_next = live_next;
                    end
                    bytes_next = bytes_reg + 38'(cost_reg);
                    if (bytes_next > bytes_peak_reg)
                    begin
                        bytes_peak_next = bytes_next;
                    end
                end
                if (evt_all.freed)
                begin
                    ok_next    = 1'b1;
                    rel_next   = rel_reg + 7'd1;
                    live_next  = live_reg - LW'(1);
                    bytes_next = bytes_reg - 38'(evt_all.bytes);
                end
                if (evt_all.stale && (stale_reg != ghtbl_pkg::SAT32))
                begin
                    stale_next = stale_reg + 32'd1;
                end
                if (chain_done)
                begin
                    // A claim whose token left the chain unfound met a full table.
                    if ((cmd_reg.op == ghtbl_pkg::OP_CLAIM) && !tok_chain[SLOTS].found
                        && (full_reg != ghtbl_pkg::SAT32))
                    begin
                        full_next = full_reg + 32'd1;
                    end
                    state_next = ST_REPORT;
                end
            end

            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launch_reg     <= 1'b0;
            cmd_reg        <= '0;
            cost_reg       <= '0;
            class_reg      <= 8'd1;
            hout_reg       <= '0;
            ok_reg         <= 1'b0;
            rel_reg        <= '0;
            live_reg       <= '0;
            live_peak_reg  <= '0;
            bytes_reg      <= '0;
            bytes_peak_reg <= '0;
            full_reg       <= '0;
            stale_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            launch_reg     <= launch_next;
            cmd_reg        <= cmd_next;
            cost_reg       <= cost_next;
            class_reg      <= class_next;
            hout_reg       <= hout_next;
            ok_reg         <= ok_next;
            rel_reg        <= rel_next;
            live_reg       <= live_next;
            live_peak_reg  <= live_peak_next;
            bytes_reg      <= bytes_next;
            bytes_peak_reg <= bytes_peak_next;
            full_reg       <= full_next;
            stale_reg      <= stale_next;
        end
    end

    assign handle_out      = hout_reg;
    assign ok              = ok_reg;
    assign released_count  = rel_reg;
    assign live_count      = 7'(live_reg);
    assign live_peak       = 7'(live_peak_reg);
    assign byte_total      = bytes_reg;
    assign byte_high_water = bytes_peak_reg;
    assign full_failures   = full_reg;
    assign stale_releases  = stale_reg;

    `GHT_CHECK(a_single_event, 1'b1, $onehot0(evt_hits), "more than one cell reported an event")
    `GHT_CHECK(a_claim_op, evt_all.claim, cmd_reg.op == ghtbl_pkg::OP_CLAIM, "claim outside claim")
    `GHT_CHECK(a_live_bound, 1'b1, live_reg <= LW'(SLOTS), "live count above slot count")
    `GHT_CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left block idle")
    `GHT_CHECK_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

`default_nettype wire
